// ===== rtl/core/ray_segment_box_slab_test_macros.svh =====
// Assertion macros for the slab test checker
`ifndef RAY_SEGMENT_BOX_SLAB_TEST_MACROS_SVH
`define RAY_SEGMENT_BOX_SLAB_TEST_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define RSB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("slab test check failed");

// Next-cycle implication checked outside reset
`define RSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("slab test check failed");

`endif

// ===== rtl/core/rsb_pkg.sv =====
// ----------------------------------------------------------------------------
// rsb_pkg
// Fixed constants shared by the segment/box slab test.
// ----------------------------------------------------------------------------
package rsb_pkg;

	// entry parameter output width (Q0.16)
	localparam int EntryBits = 16;

endpackage

// ===== rtl/core/rsb_divider.sv =====
// ----------------------------------------------------------------------------
// rsb_divider
// Pipelined restoring divider for one slab parameter: one quotient bit per
// stage, signed result truncated toward zero and saturated to [-1, 2].
// ----------------------------------------------------------------------------
module rsb_divider
	import rsb_pkg::*;
#(
	parameter int NumBits  = 33,
	parameter int FracBits = 16
) (
	input  logic                       clk,
	input  logic signed [NumBits-1:0]  num,
	input  logic signed [NumBits-1:0]  den,
	output logic signed [FracBits+2:0] quo
);
	localparam int Stages = FracBits + 1;
	localparam int RBits  = NumBits + 1;
	localparam int QBits  = FracBits + 2;

	logic [RBits-1:0] r_s    [Stages+1];
	logic [RBits-1:0] d_s    [Stages+1];
	logic [QBits-1:0] q_s    [Stages+1];
	logic             neg_s  [Stages+1];
	logic             sat_s  [Stages+1];

	logic [NumBits-1:0] un, ud;
	logic [RBits-1:0]   un2;

	// magnitudes and early saturation
	always_comb begin
		un  = num[NumBits-1] ? NumBits'(-num) : NumBits'(num);
		ud  = den[NumBits-1] ? NumBits'(-den) : NumBits'(den);
		un2 = {1'b0, ud} << 1;
	end

	always_ff @(posedge clk) begin
		r_s[0]   <= {1'b0, un};
		d_s[0]   <= {1'b0, ud};
		q_s[0]   <= '0;
		neg_s[0] <= num[NumBits-1] ^ den[NumBits-1];
		sat_s[0] <= ({1'b0, un} >= un2);
	end

	// one quotient bit per stage; stage 0 yields the integer bit
	for (genvar i = 0; i < Stages; i++) begin : g_st
		logic [RBits-1:0] rn;
		logic             ge;
		always_comb begin
			rn = (i == 0) ? r_s[i] : (r_s[i] << 1);
			ge = rn >= d_s[i];
		end
		always_ff @(posedge clk) begin
			r_s[i+1]   <= ge ? rn - d_s[i] : rn;
			d_s[i+1]   <= d_s[i];
			q_s[i+1]   <= {q_s[i][QBits-2:0], ge};
			neg_s[i+1] <= neg_s[i];
			sat_s[i+1] <= sat_s[i];
		end
	end

	logic [QBits-1:0] mag;
	always_comb begin
		mag = sat_s[Stages] ? QBits'(2) << FracBits : q_s[Stages];
		if (neg_s[Stages] && mag > (QBits'(1) << FracBits))
			mag = QBits'(1) << FracBits;
		quo = neg_s[Stages] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end
endmodule

// ===== rtl/core/ray_segment_box_slab_test.sv =====
// ----------------------------------------------------------------------------
// ray_segment_box_slab_test
// Segment versus axis-aligned box slab test with hit point.
// ----------------------------------------------------------------------------
// Usage: drive all twelve coordinates with start high; an item is taken at
// any edge where start is high and busy is low. busy is tied low: the
// pipeline takes one item every cycle and never stalls.
// Each item yields exactly one result, shown for one cycle with done high:
// hit, the hit point and the entry parameter (zeros on a miss).
// Pipeline: one input register, one register for differences,
// PARAM_FRAC_BITS+1 divider stages (one quotient bit each) plus its
// entry register, one ordering/narrowing stage, one multiply stage and
// one output stage.
// Throughput: one item per cycle, set by the bit-per-stage divider.
// Reset clears the valid bits only; results in flight are dropped.
// The receiver cannot stall; results must be taken as shown.
// ----------------------------------------------------------------------------
module ray_segment_box_slab_test
	import rsb_pkg::*;
#(
	parameter int COORD_BITS      = 32,
	parameter int PARAM_FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] start_z,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic signed [COORD_BITS-1:0] end_z,
	input  logic signed [COORD_BITS-1:0] box_lo_x,
	input  logic signed [COORD_BITS-1:0] box_lo_y,
	input  logic signed [COORD_BITS-1:0] box_lo_z,
	input  logic signed [COORD_BITS-1:0] box_hi_x,
	input  logic signed [COORD_BITS-1:0] box_hi_y,
	input  logic signed [COORD_BITS-1:0] box_hi_z,
	output logic                         done,
	output logic                         hit,
	output logic signed [COORD_BITS-1:0] hit_x,
	output logic signed [COORD_BITS-1:0] hit_y,
	output logic signed [COORD_BITS-1:0] hit_z,
	output logic [EntryBits-1:0]         entry_param
);
	localparam int CB    = COORD_BITS;
	localparam int DB    = COORD_BITS + 1;
	localparam int F     = PARAM_FRAC_BITS;
	localparam int TB    = F + 3;
	localparam int DivLat = F + 2;
	localparam int Lat1  = DivLat;

	assign busy = 1'b0;

	// stage 1: input register
	logic                v_s1;
	logic signed [CB-1:0] s_s1 [3], e_s1 [3], lo_s1 [3], hi_s1 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		s_s1  <= '{start_x, start_y, start_z};
		e_s1  <= '{end_x, end_y, end_z};
		lo_s1 <= '{box_lo_x, box_lo_y, box_lo_z};
		hi_s1 <= '{box_hi_x, box_hi_y, box_hi_z};
	end

	// stage 2: differences and parallel-slab miss
	logic                v_s2;
	logic signed [DB-1:0] d_s2 [3], nl_s2 [3], nh_s2 [3];
	logic signed [CB-1:0] s_s2 [3];
	logic [2:0]           par_s2, pmiss_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end
	for (genvar a = 0; a < 3; a++) begin : g_diff
		logic signed [DB-1:0] d;
		assign d = DB'(e_s1[a]) - DB'(s_s1[a]);
		always_ff @(posedge clk) begin
			d_s2[a]     <= d;
			nl_s2[a]    <= DB'(lo_s1[a]) - DB'(s_s1[a]);
			nh_s2[a]    <= DB'(hi_s1[a]) - DB'(s_s1[a]);
			s_s2[a]     <= s_s1[a];
			par_s2[a]   <= (d == '0);
			pmiss_s2[a] <= (s_s1[a] < lo_s1[a]) || (s_s1[a] > hi_s1[a]);
		end
	end

	// dividers: six slab parameters
	logic signed [TB-1:0] t1_q [3], t2_q [3];
	for (genvar a = 0; a < 3; a++) begin : g_div
		logic signed [DB-1:0] den;
		assign den = par_s2[a] ? DB'(1) : d_s2[a];
		rsb_divider #(.NumBits(DB), .FracBits(F)) u_lo (
			.clk(clk), .num(nl_s2[a]), .den(den), .quo(t1_q[a]));
		rsb_divider #(.NumBits(DB), .FracBits(F)) u_hi (
			.clk(clk), .num(nh_s2[a]), .den(den), .quo(t2_q[a]));
	end

	// delay line for side data through the divider
	logic                v_d   [Lat1];
	logic signed [DB-1:0] d_d  [Lat1][3];
	logic signed [CB-1:0] s_d  [Lat1][3];
	logic [2:0]           par_d [Lat1];
	logic                 pm_d  [Lat1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Lat1; i++) v_d[i] <= 1'b0;
		end else begin
			v_d[0] <= v_s2;
			for (int i = 1; i < Lat1; i++) v_d[i] <= v_d[i-1];
		end
	end
	always_ff @(posedge clk) begin
		d_d[0]   <= d_s2;
		s_d[0]   <= s_s2;
		par_d[0] <= par_s2;
		pm_d[0]  <= |(par_s2 & pmiss_s2);
		for (int i = 1; i < Lat1; i++) begin
			d_d[i]   <= d_d[i-1];
			s_d[i]   <= s_d[i-1];
			par_d[i] <= par_d[i-1];
			pm_d[i]  <= pm_d[i-1];
		end
	end

	// stage 3: order slab parameters, narrow interval, decide hit
	logic signed [TB-1:0] tmin, tmax, lo_t, hi_t;
	logic                 miss;
	always_comb begin
		tmin = '0;
		tmax = TB'(2) << F;
		for (int a = 0; a < 3; a++) begin
			lo_t = (t1_q[a] > t2_q[a]) ? t2_q[a] : t1_q[a];
			hi_t = (t1_q[a] > t2_q[a]) ? t1_q[a] : t2_q[a];
			if (!par_d[Lat1-1][a]) begin
				if (lo_t > tmin) tmin = lo_t;
				if (hi_t < tmax) tmax = hi_t;
			end
		end
		miss = pm_d[Lat1-1] || (tmin > tmax) || !(tmin > 0 && tmin < (TB'(1) << F));
	end

	logic                 v_s3, hit_s3;
	logic [F-1:0]         t_s3;
	logic signed [DB-1:0] d_s3 [3];
	logic signed [CB-1:0] s_s3 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_d[Lat1-1];
	end
	always_ff @(posedge clk) begin
		hit_s3 <= !miss;
		t_s3   <= tmin[F-1:0];
		d_s3   <= d_d[Lat1-1];
		s_s3   <= s_d[Lat1-1];
	end

	// stage 4: d * tmin
	localparam int PB = DB + F + 1;
	logic                 v_s4, hit_s4;
	logic [F-1:0]         t_s4;
	logic signed [PB-1:0] p_s4 [3];
	logic signed [CB-1:0] s_s4 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		hit_s4 <= hit_s3;
		t_s4   <= t_s3;
		s_s4   <= s_s3;
		for (int a = 0; a < 3; a++)
			p_s4[a] <= PB'(d_s3[a]) * $signed(PB'({1'b0, t_s3}));
	end

	// stage 5: add, scale entry parameter, output register
	logic [EntryBits-1:0] ep;
	always_comb begin
		if (F >= EntryBits) ep = EntryBits'(t_s4 >> (F - EntryBits));
		else                ep = EntryBits'({t_s4, {(EntryBits > F ? EntryBits - F : 1){1'b0}}} >>
			(EntryBits > F ? 0 : 1));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= v_s4;
	end
	always_ff @(posedge clk) begin
		hit         <= hit_s4;
		hit_x       <= hit_s4 ? s_s4[0] + CB'(p_s4[0] >>> F) : '0;
		hit_y       <= hit_s4 ? s_s4[1] + CB'(p_s4[1] >>> F) : '0;
		hit_z       <= hit_s4 ? s_s4[2] + CB'(p_s4[2] >>> F) : '0;
		entry_param <= hit_s4 ? ep : '0;
	end
endmodule

// ===== rtl/core/rsb_checker.sv =====
// ----------------------------------------------------------------------------
// rsb_checker
// Port-level checks on the slab test, bound to the top level.
// ----------------------------------------------------------------------------
`include "ray_segment_box_slab_test_macros.svh"

module rsb_checker
	import rsb_pkg::*;
#(
	parameter int CoordBits = 32
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 busy,
	input logic                 done,
	input logic                 hit,
	input logic [CoordBits-1:0] hit_x,
	input logic [EntryBits-1:0] entry_param
);
	// never refuses an item
	`RSB_ASSERT_IMP(a_never_busy, clk, arst_n, 1'b1, !busy)
	// a miss reports a zero entry parameter
	`RSB_ASSERT_IMP(a_miss_zero_ep, clk, arst_n, done && !hit, entry_param == '0)
	// a miss reports a zero x coordinate
	`RSB_ASSERT_IMP(a_miss_zero_x, clk, arst_n, done && !hit, hit_x == '0)
	// a hit has a nonzero entry parameter
	`RSB_ASSERT_IMP(a_hit_ep, clk, arst_n, done && hit, entry_param != '0)
endmodule

bind ray_segment_box_slab_test rsb_checker #(.CoordBits(COORD_BITS)) u_rsb_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy), .done(done), .hit(hit),
	.hit_x(hit_x), .entry_param(entry_param));
